### rtl/afrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive frame rate gate package
// Shared widths, action and verdict codes, reset values and the
// controller-to-datapath command and status types.
// ----------------------------------------------------------------------------
package afrg_pkg;

   localparam int FPS_WIDTH     = 7;
   localparam int SPACING_WIDTH = 10;
   localparam int COUNT_WIDTH   = 32;
   localparam int ACTION_WIDTH  = 3;
   localparam int VERDICT_WIDTH = 2;

   localparam logic [ACTION_WIDTH-1:0] ACT_FRAME   = 3'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_VERDICT = 3'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_PAUSE   = 3'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_RESUME  = 3'd3;
   localparam logic [ACTION_WIDTH-1:0] ACT_START   = 3'd4;
   localparam logic [ACTION_WIDTH-1:0] ACT_STOP    = 3'd5;

   localparam logic [VERDICT_WIDTH-1:0] VERDICT_HOLD     = 2'd0;
   localparam logic [VERDICT_WIDTH-1:0] VERDICT_INCREASE = 2'd1;

   localparam logic [FPS_WIDTH-1:0]     MIN_FPS           = 7'd3;
   localparam logic [FPS_WIDTH-1:0]     RESET_TARGET_FPS  = 7'd30;
   localparam logic [SPACING_WIDTH-1:0] RESET_SPACING     = 10'd33;
   localparam logic [SPACING_WIDTH-1:0] DIV_DIVIDEND      = 10'd1000;
   localparam logic [SPACING_WIDTH-1:0] ZERO_RATE_SPACING = 10'd1000;

   localparam int DIV_STEPS     = SPACING_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

   typedef struct packed {
      logic capture;
      logic exec;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
      logic out_free;
   } ctrl_status_type;

endpackage

### rtl/afrg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive frame rate gate controller
// Sequences one item: capture, state update, optional rate division and
// hand-off to the output register.
// ----------------------------------------------------------------------------
module afrg_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  afrg_pkg::ctrl_status_type status,
   output afrg_pkg::ctrl_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.need_div ? ST_DIV : ST_RESP;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/afrg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive frame rate gate datapath
// Holds the gate state, the rate register, a restoring divider for the
// frame spacing and the output register.
// ----------------------------------------------------------------------------
module afrg_datapath #(
   parameter int TIME_WIDTH = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  afrg_pkg::ctrl_cmd_type               cmd,
   output afrg_pkg::ctrl_status_type            status,
   input  logic                                 csr_wr_en,
   input  logic [afrg_pkg::FPS_WIDTH-1:0]       csr_wr_data,
   input  logic [afrg_pkg::ACTION_WIDTH-1:0]    req_action,
   input  logic [TIME_WIDTH-1:0]                req_now_ms,
   input  logic [afrg_pkg::VERDICT_WIDTH-1:0]   req_verdict,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic                                 rsp_pass_frame,
   output logic                                 rsp_dropped_paused,
   output logic [TIME_WIDTH-1:0]                rsp_elapsed_ms,
   output logic [afrg_pkg::COUNT_WIDTH-1:0]     rsp_frames_accepted,
   output logic [afrg_pkg::FPS_WIDTH-1:0]       rsp_current_fps,
   output logic [afrg_pkg::SPACING_WIDTH-1:0]   rsp_interval_ms
);

   localparam int FW = afrg_pkg::FPS_WIDTH;
   localparam int SW = afrg_pkg::SPACING_WIDTH;
   localparam int CW = afrg_pkg::COUNT_WIDTH;

   logic [afrg_pkg::ACTION_WIDTH-1:0]  act_ff;
   logic [TIME_WIDTH-1:0]              now_ff;
   logic [afrg_pkg::VERDICT_WIDTH-1:0] verdict_ff;

   logic [FW-1:0]         target_ff,  target_in;
   logic [FW-1:0]         fps_ff,     fps_in;
   logic [SW-1:0]         spacing_ff, spacing_in;
   logic [TIME_WIDTH-1:0] start_ff,   start_in;
   logic                  start_valid_ff, start_valid_in;
   logic [TIME_WIDTH-1:0] last_ff,    last_in;
   logic                  last_valid_ff, last_valid_in;
   logic [TIME_WIDTH-1:0] pending_ff, pending_in;
   logic [CW-1:0]         count_ff,   count_in;
   logic                  paused_ff,  paused_in;

   logic                  pass_ff,    pass_in;
   logic                  dropped_ff, dropped_in;
   logic [TIME_WIDTH-1:0] elapsed_ff, elapsed_in;

   logic [FW-1:0]                      rem_ff, rem_in;
   logic [SW-1:0]                      dsr_ff, dsr_in;
   logic [SW-1:0]                      quo_ff, quo_in;
   logic [afrg_pkg::DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [FW:0]                        div_shift;
   logic                               div_ge;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TIME_WIDTH-1:0] frame_diff;
   logic                  frame_push;
   logic                  need_div;

   assign frame_diff = now_ff - last_ff;
   assign frame_push = !start_valid_ff || !last_valid_ff ||
                       ((now_ff >= last_ff) &&
                        (frame_diff >= {{(TIME_WIDTH-SW){1'b0}}, spacing_ff}));

   always_comb begin
      need_div = 1'b0;
      if (act_ff == afrg_pkg::ACT_START) begin
         need_div = 1'b1;
      end else if (act_ff == afrg_pkg::ACT_VERDICT) begin
         if (verdict_ff == afrg_pkg::VERDICT_INCREASE) begin
            need_div = fps_ff < target_ff;
         end else begin
            need_div = verdict_ff != afrg_pkg::VERDICT_HOLD;
         end
      end
   end

   assign div_shift = {rem_ff, dsr_ff[SW-1]};
   assign div_ge    = div_shift >= {1'b0, fps_ff};

   assign status.need_div = need_div;
   assign status.div_last = cnt_ff == afrg_pkg::DIV_CNT_WIDTH'(afrg_pkg::DIV_STEPS - 1);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      target_in      = target_ff;
      fps_in         = fps_ff;
      spacing_in     = spacing_ff;
      start_in       = start_ff;
      start_valid_in = start_valid_ff;
      last_in        = last_ff;
      last_valid_in  = last_valid_ff;
      pending_in     = pending_ff;
      count_in       = count_ff;
      paused_in      = paused_ff;
      pass_in        = pass_ff;
      dropped_in     = dropped_ff;
      elapsed_in     = elapsed_ff;
      rem_in         = rem_ff;
      dsr_in         = dsr_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;

      if (csr_wr_en) begin
         target_in = csr_wr_data;
      end

      if (cmd.exec) begin
         pass_in    = 1'b0;
         dropped_in = 1'b0;
         elapsed_in = '0;
         rem_in     = '0;
         dsr_in     = afrg_pkg::DIV_DIVIDEND;
         quo_in     = '0;
         cnt_in     = '0;
         unique case (act_ff)
            afrg_pkg::ACT_FRAME: begin
               if (paused_ff) begin
                  dropped_in = 1'b1;
               end else begin
                  if (!start_valid_ff) begin
                     start_in       = now_ff;
                     start_valid_in = 1'b1;
                  end
                  if (!last_valid_ff) begin
                     last_in       = now_ff;
                     last_valid_in = 1'b1;
                  end
                  if (frame_push) begin
                     pass_in    = 1'b1;
                     pending_in = now_ff;
                     if (start_valid_ff && (now_ff >= start_ff)) begin
                        elapsed_in = now_ff - start_ff;
                     end
                  end
               end
            end
            afrg_pkg::ACT_VERDICT: begin
               if ((verdict_ff == afrg_pkg::VERDICT_HOLD) ||
                   (verdict_ff == afrg_pkg::VERDICT_INCREASE)) begin
                  count_in      = CW'(count_ff + 1'b1);
                  last_in       = pending_ff;
                  last_valid_in = 1'b1;
                  if (need_div) begin
                     fps_in = FW'(fps_ff + 1'b1);
                  end
               end else begin
                  fps_in = (fps_ff <= afrg_pkg::MIN_FPS) ? afrg_pkg::MIN_FPS
                                                         : FW'(fps_ff - 1'b1);
               end
            end
            afrg_pkg::ACT_PAUSE: begin
               paused_in = 1'b1;
            end
            afrg_pkg::ACT_RESUME: begin
               paused_in = 1'b0;
            end
            afrg_pkg::ACT_START: begin
               fps_in = target_ff;
            end
            afrg_pkg::ACT_STOP: begin
               start_valid_in = 1'b0;
               last_valid_in  = 1'b0;
               count_in       = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.div_step) begin
         rem_in = div_ge ? FW'(div_shift - {1'b0, fps_ff}) : div_shift[FW-1:0];
         quo_in = {quo_ff[SW-2:0], div_ge};
         dsr_in = {dsr_ff[SW-2:0], 1'b0};
         cnt_in = afrg_pkg::DIV_CNT_WIDTH'(cnt_ff + 1'b1);
         if (status.div_last) begin
            spacing_in = (fps_ff == '0) ? afrg_pkg::ZERO_RATE_SPACING
                                        : {quo_ff[SW-2:0], div_ge};
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff      <= afrg_pkg::RESET_TARGET_FPS;
         fps_ff         <= afrg_pkg::RESET_TARGET_FPS;
         spacing_ff     <= afrg_pkg::RESET_SPACING;
         start_ff       <= '0;
         start_valid_ff <= 1'b0;
         last_ff        <= '0;
         last_valid_ff  <= 1'b0;
         pending_ff     <= '0;
         count_ff       <= '0;
         paused_ff      <= 1'b0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         target_ff      <= target_in;
         fps_ff         <= fps_in;
         spacing_ff     <= spacing_in;
         start_ff       <= start_in;
         start_valid_ff <= start_valid_in;
         last_ff        <= last_in;
         last_valid_ff  <= last_valid_in;
         pending_ff     <= pending_in;
         count_ff       <= count_in;
         paused_ff      <= paused_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff    <= pass_in;
      dropped_ff <= dropped_in;
      elapsed_ff <= elapsed_in;
      rem_ff     <= rem_in;
      dsr_ff     <= dsr_in;
      quo_ff     <= quo_in;
      if (cmd.capture) begin
         act_ff     <= req_action;
         now_ff     <= req_now_ms;
         verdict_ff <= req_verdict;
      end
      if (cmd.out_load) begin
         rsp_pass_frame      <= pass_ff;
         rsp_dropped_paused  <= dropped_ff;
         rsp_elapsed_ms      <= elapsed_ff;
         rsp_frames_accepted <= count_ff;
         rsp_current_fps     <= fps_ff;
         rsp_interval_ms     <= spacing_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/adaptive_frame_rate_gate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive frame rate gate
// Passes video frames at an adaptive rate steered by encoder verdicts.
//
//   Channel  Direction  Handshake                 Payload
//   req      in         req_valid / req_stall     action, now_ms, verdict
//   rsp      out        rsp_valid / rsp_stall     pass, drop, elapsed, count,
//                                                 fps, interval
//   csr      in         csr_wr_en                 target_fps
//
// An item passes the exec and response states, and the divide state as well
// when it is a start, a verdict other than hold or increase, or an increase
// below the target; the frame spacing then comes from a restoring divider
// that produces one quotient bit per cycle. Only one item is in flight; the
// next is taken once the current result has moved into the output register,
// which may still wait on rsp_stall. Synchronous reset sets a 30 fps target.
// ----------------------------------------------------------------------------
module adaptive_frame_rate_gate_top #(
   parameter int TIME_WIDTH = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [afrg_pkg::FPS_WIDTH-1:0]      csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [afrg_pkg::ACTION_WIDTH-1:0]   req_action,
   input  logic [TIME_WIDTH-1:0]               req_now_ms,
   input  logic [afrg_pkg::VERDICT_WIDTH-1:0]  req_verdict,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_pass_frame,
   output logic                                rsp_dropped_paused,
   output logic [TIME_WIDTH-1:0]               rsp_elapsed_ms,
   output logic [afrg_pkg::COUNT_WIDTH-1:0]    rsp_frames_accepted,
   output logic [afrg_pkg::FPS_WIDTH-1:0]      rsp_current_fps,
   output logic [afrg_pkg::SPACING_WIDTH-1:0]  rsp_interval_ms
);

   afrg_pkg::ctrl_cmd_type    cmd;
   afrg_pkg::ctrl_status_type status;

   afrg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   afrg_datapath #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_action          (req_action),
      .req_now_ms          (req_now_ms),
      .req_verdict         (req_verdict),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_pass_frame      (rsp_pass_frame),
      .rsp_dropped_paused  (rsp_dropped_paused),
      .rsp_elapsed_ms      (rsp_elapsed_ms),
      .rsp_frames_accepted (rsp_frames_accepted),
      .rsp_current_fps     (rsp_current_fps),
      .rsp_interval_ms     (rsp_interval_ms)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("A second item was taken while one is in flight.");

   a_pass_or_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pass_frame && rsp_dropped_paused))
      else $error("A frame is reported both passed and dropped.");

   a_interval_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_interval_ms != '0) &&
                     (rsp_interval_ms <= afrg_pkg::ZERO_RATE_SPACING)))
      else $error("The reported interval is out of range.");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive frame rate gate testbench
// Sends frame, encoder verdict and capture control items through the gate
// under random sender gaps and receiver stalls, and across several target
// rates. Each accepted item is run through a local copy of the gate's rate
// and timing state, and every result field is checked against that outcome.
// ----------------------------------------------------------------------------
module tb;

   localparam int TIME_W       = 48;
   localparam int MS_PER_S     = 1000;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SHOWN_ERRORS = 40;
   localparam int PHASE_ITEMS  = 55;

   localparam int AW = afrg_pkg::ACTION_WIDTH;
   localparam int VW = afrg_pkg::VERDICT_WIDTH;
   localparam int FW = afrg_pkg::FPS_WIDTH;
   localparam int SW = afrg_pkg::SPACING_WIDTH;
   localparam int CW = afrg_pkg::COUNT_WIDTH;

   localparam logic [AW-1:0] ACT_SPARE_6      = 3'd6;
   localparam logic [AW-1:0] ACT_SPARE_7      = 3'd7;
   localparam logic [VW-1:0] VERDICT_DECREASE = 2'd2;
   localparam logic [VW-1:0] VERDICT_SPARE    = 2'd3;

   typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_mode_type;

   typedef struct packed {
      logic [AW-1:0]     action;
      logic [TIME_W-1:0] now_ms;
      logic [VW-1:0]     verdict;
   } gate_item_type;

   typedef struct packed {
      logic              pass_frame;
      logic              dropped_paused;
      logic [TIME_W-1:0] elapsed_ms;
      logic [CW-1:0]     frames_accepted;
      logic [FW-1:0]     current_fps;
      logic [SW-1:0]     interval_ms;
   } gate_result_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_wr_en   = 1'b0;
   logic [FW-1:0]     csr_wr_data = '0;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   logic [AW-1:0]     req_action  = '0;
   logic [TIME_W-1:0] req_now_ms  = '0;
   logic [VW-1:0]     req_verdict = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   logic              rsp_pass_frame;
   logic              rsp_dropped_paused;
   logic [TIME_W-1:0] rsp_elapsed_ms;
   logic [CW-1:0]     rsp_frames_accepted;
   logic [FW-1:0]     rsp_current_fps;
   logic [SW-1:0]     rsp_interval_ms;

   adaptive_frame_rate_gate_top #(
      .TIME_WIDTH(TIME_W)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_now_ms         (req_now_ms),
      .req_verdict        (req_verdict),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pass_frame     (rsp_pass_frame),
      .rsp_dropped_paused (rsp_dropped_paused),
      .rsp_elapsed_ms     (rsp_elapsed_ms),
      .rsp_frames_accepted(rsp_frames_accepted),
      .rsp_current_fps    (rsp_current_fps),
      .rsp_interval_ms    (rsp_interval_ms)
   );

   // Gate state as the block should hold it, updated as items are accepted.
   logic [FW-1:0]     target_fps_reg = afrg_pkg::RESET_TARGET_FPS;
   logic [FW-1:0]     fps_now        = afrg_pkg::RESET_TARGET_FPS;
   logic [SW-1:0]     spacing_ms     = SW'(MS_PER_S / 30);
   logic [TIME_W-1:0] start_ms       = '0;
   logic              start_ok       = 1'b0;
   logic [TIME_W-1:0] last_ms        = '0;
   logic              last_ok        = 1'b0;
   logic [TIME_W-1:0] pending_ms     = '0;
   logic [CW-1:0]     accepted_cnt   = '0;
   logic              cap_paused     = 1'b0;

   gate_item_type   request_q[$];
   gate_result_type outcome_q[$];

   logic [TIME_W-1:0] stim_ms = '0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   int gap_left       = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int stall_left     = 0;
   int hold_left      = 0;
   int stall_cycles   = 0;
   int next_hold      = 1500;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [SW-1:0] rate_spacing(input logic [FW-1:0] fps);
      if (fps == '0) begin
         return SW'(MS_PER_S);
      end
      return SW'(MS_PER_S / int'(fps));
   endfunction

   function automatic gate_result_type gate_frame_item(input gate_item_type it);
      gate_result_type res;
      logic            push;
      res  = '0;
      push = 1'b0;
      case (it.action)
         afrg_pkg::ACT_FRAME: begin
            if (cap_paused) begin
               res.dropped_paused = 1'b1;
            end else begin
               if (!start_ok) begin
                  start_ms = it.now_ms;
                  start_ok = 1'b1;
                  push     = 1'b1;
               end
               if (!last_ok) begin
                  last_ms = it.now_ms;
                  last_ok = 1'b1;
                  push    = 1'b1;
               end
               if (!push) begin
                  push = (it.now_ms >= last_ms) &&
                         ((it.now_ms - last_ms) >= TIME_W'(spacing_ms));
               end
               if (push) begin
                  res.pass_frame = 1'b1;
                  pending_ms     = it.now_ms;
                  res.elapsed_ms = (it.now_ms >= start_ms) ? it.now_ms - start_ms : '0;
               end
            end
         end
         afrg_pkg::ACT_VERDICT: begin
            if (it.verdict == afrg_pkg::VERDICT_HOLD ||
                it.verdict == afrg_pkg::VERDICT_INCREASE) begin
               accepted_cnt = accepted_cnt + 1'b1;
               last_ms      = pending_ms;
               last_ok      = 1'b1;
               if (it.verdict == afrg_pkg::VERDICT_INCREASE &&
                   fps_now < target_fps_reg) begin
                  fps_now    = fps_now + 1'b1;
                  spacing_ms = rate_spacing(fps_now);
               end
            end else begin
               fps_now    = (fps_now <= afrg_pkg::MIN_FPS) ? afrg_pkg::MIN_FPS
                                                          : fps_now - 1'b1;
               spacing_ms = rate_spacing(fps_now);
            end
         end
         afrg_pkg::ACT_PAUSE: cap_paused = 1'b1;
         afrg_pkg::ACT_RESUME: cap_paused = 1'b0;
         afrg_pkg::ACT_START: begin
            fps_now    = target_fps_reg;
            spacing_ms = rate_spacing(fps_now);
         end
         afrg_pkg::ACT_STOP: begin
            start_ok     = 1'b0;
            last_ok      = 1'b0;
            accepted_cnt = '0;
         end
         default: ;
      endcase
      res.frames_accepted = accepted_cnt;
      res.current_fps     = fps_now;
      res.interval_ms     = spacing_ms;
      return res;
   endfunction

   function automatic logic [TIME_W-1:0] rand_ms();
      return TIME_W'({$urandom(), $urandom()});
   endfunction

   task automatic queue_request(input logic [AW-1:0] action,
                                input logic [TIME_W-1:0] now_ms,
                                input logic [VW-1:0] verdict);
      gate_item_type it;
      it.action  = action;
      it.now_ms  = now_ms;
      it.verdict = verdict;
      request_q.push_back(it);
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] exp_val);
      if (mismatch_count < SHOWN_ERRORS) begin
         $display("%0t: %s got 0x%0h, expected 0x%0h", $time, field, got, exp_val);
      end
      mismatch_count++;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (request_q.size() != 0 || req_valid || outcome_q.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_target(input logic [FW-1:0] fps);
      @(posedge clock);
      csr_wr_en      <= 1'b1;
      csr_wr_data    <= fps;
      target_fps_reg = fps;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic add_session(input int count);
      int hint;
      int made;
      int pick;
      int k;
      logic [VW-1:0] vd;
      logic [AW-1:0] act;
      hint = (target_fps_reg == '0) ? MS_PER_S : MS_PER_S / int'(target_fps_reg);
      made = 0;
      if ($urandom_range(0, 1) == 1) begin
         queue_request(afrg_pkg::ACT_STOP, rand_ms(), VW'($urandom_range(0, 3)));
         made++;
      end
      queue_request(afrg_pkg::ACT_START, rand_ms(), VW'($urandom_range(0, 3)));
      made++;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            stim_ms = stim_ms + TIME_W'($urandom_range(0, 2 * hint + 2));
            queue_request(afrg_pkg::ACT_FRAME, stim_ms, VW'($urandom_range(0, 3)));
            made++;
            if ($urandom_range(0, 99) < 85) begin
               k = $urandom_range(0, 19);
               vd = (k < 6) ? afrg_pkg::VERDICT_HOLD :
                    (k < 14) ? afrg_pkg::VERDICT_INCREASE :
                    (k < 19) ? VERDICT_DECREASE : VERDICT_SPARE;
               queue_request(afrg_pkg::ACT_VERDICT, rand_ms(), vd);
               made++;
            end
         end else if (pick < 78) begin
            queue_request(afrg_pkg::ACT_PAUSE, rand_ms(), VW'($urandom_range(0, 3)));
            repeat ($urandom_range(1, 3)) begin
               stim_ms = stim_ms + TIME_W'($urandom_range(0, 2 * hint));
               queue_request(afrg_pkg::ACT_FRAME, stim_ms, VW'($urandom_range(0, 3)));
               made++;
            end
            queue_request(afrg_pkg::ACT_RESUME, rand_ms(), VW'($urandom_range(0, 3)));
            made += 2;
         end else if (pick < 82) begin
            queue_request(afrg_pkg::ACT_STOP, rand_ms(), VW'($urandom_range(0, 3)));
            made++;
         end else if (pick < 86) begin
            queue_request(afrg_pkg::ACT_START, rand_ms(), VW'($urandom_range(0, 3)));
            made++;
         end else if (pick < 90) begin
            queue_request(afrg_pkg::ACT_FRAME,
                          stim_ms - TIME_W'($urandom_range(1, 2 * hint)),
                          VW'($urandom_range(0, 3)));
            made++;
         end else if (pick < 95) begin
            act = AW'($urandom_range(0, 7));
            queue_request(act, rand_ms(), VW'($urandom_range(0, 3)));
            if (act != ACT_SPARE_6 && act != ACT_SPARE_7) begin
               made++;
            end
         end else begin
            stim_ms = rand_ms();
            queue_request(afrg_pkg::ACT_FRAME, stim_ms, VW'($urandom_range(0, 3)));
            made++;
         end
      end
   endtask

   always @(posedge clock) begin : drive_proc
      gate_item_type cur;
      gate_item_type nxt;
      logic          busy;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         busy = req_valid;
         if (req_valid && !req_stall) begin
            cur.action  = req_action;
            cur.now_ms  = req_now_ms;
            cur.verdict = req_verdict;
            outcome_q.push_back(gate_frame_item(cur));
            busy = 1'b0;
         end
         if (!busy) begin
            if (gap_left > 0 || request_q.size() == 0) begin
               if (gap_left > 0) begin
                  gap_left--;
               end
               req_valid <= 1'b0;
            end else begin
               nxt = request_q.pop_front();
               req_valid   <= 1'b1;
               req_action  <= nxt.action;
               req_now_ms  <= nxt.now_ms;
               req_verdict <= nxt.verdict;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(0, 23);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : stall_proc
      logic stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_cycles++;
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (stall_cycles >= next_hold && rsp_valid) begin
            hold_left  = 300;
            next_hold  = stall_cycles + 4000;
            stall_next = 1'b1;
         end else begin
            if (stall_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 2));
               stall_left = $urandom_range(16, 80);
            end
            stall_left--;
            case (stall_mode)
               STALL_NONE: stall_next = 1'b0;
               STALL_HALF: stall_next = ($urandom_range(0, 1) == 1);
               default: stall_next = ($urandom_range(0, 3) != 0);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   always @(posedge clock) begin : check_proc
      gate_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            report_mismatch("result with nothing expected, count",
                            64'(rsp_frames_accepted), '0);
         end else begin
            exp_res = outcome_q.pop_front();
            if (rsp_pass_frame !== exp_res.pass_frame)
               report_mismatch("pass_frame", 64'(rsp_pass_frame),
                               64'(exp_res.pass_frame));
            if (rsp_dropped_paused !== exp_res.dropped_paused)
               report_mismatch("dropped_paused", 64'(rsp_dropped_paused),
                               64'(exp_res.dropped_paused));
            if (rsp_elapsed_ms !== exp_res.elapsed_ms)
               report_mismatch("elapsed_ms", 64'(rsp_elapsed_ms),
                               64'(exp_res.elapsed_ms));
            if (rsp_frames_accepted !== exp_res.frames_accepted)
               report_mismatch("frames_accepted", 64'(rsp_frames_accepted),
                               64'(exp_res.frames_accepted));
            if (rsp_current_fps !== exp_res.current_fps)
               report_mismatch("current_fps", 64'(rsp_current_fps),
                               64'(exp_res.current_fps));
            if (rsp_interval_ms !== exp_res.interval_ms)
               report_mismatch("interval_ms", 64'(rsp_interval_ms),
                               64'(exp_res.interval_ms));
         end
      end
   end

   always @(posedge clock) begin : limit_proc
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : stimulus
      logic [FW-1:0] rate_plan[$];
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Opening checks at the reset target of 30 fps.
      queue_request(afrg_pkg::ACT_FRAME,   TIME_W'(100), afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_VERDICT, rand_ms(), afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_FRAME,   TIME_W'(120), afrg_pkg::VERDICT_INCREASE);
      queue_request(afrg_pkg::ACT_FRAME,   TIME_W'(133), afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_VERDICT, rand_ms(), afrg_pkg::VERDICT_INCREASE);
      queue_request(afrg_pkg::ACT_VERDICT, rand_ms(), VERDICT_DECREASE);
      queue_request(afrg_pkg::ACT_VERDICT, rand_ms(), VERDICT_SPARE);
      queue_request(afrg_pkg::ACT_FRAME,   TIME_W'(50), VERDICT_SPARE);
      queue_request(afrg_pkg::ACT_PAUSE,   rand_ms(), afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_FRAME,   TIME_W'(1000), afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_RESUME,  rand_ms(), afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_FRAME,   '1, afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_VERDICT, '0, afrg_pkg::VERDICT_INCREASE);
      queue_request(afrg_pkg::ACT_STOP,    '1, VERDICT_SPARE);
      queue_request(afrg_pkg::ACT_FRAME,   '0, afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_VERDICT, rand_ms(), afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_START,   rand_ms(), afrg_pkg::VERDICT_HOLD);
      queue_request(ACT_SPARE_6,           rand_ms(), afrg_pkg::VERDICT_INCREASE);
      queue_request(ACT_SPARE_7,           rand_ms(), VERDICT_SPARE);
      queue_request(afrg_pkg::ACT_VERDICT, rand_ms(), afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_FRAME,   TIME_W'(200), afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_STOP,    rand_ms(), afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_VERDICT, rand_ms(), afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_FRAME,   TIME_W'(5000), afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_FRAME,   TIME_W'(300), afrg_pkg::VERDICT_HOLD);
      queue_request(afrg_pkg::ACT_VERDICT, rand_ms(), VERDICT_DECREASE);
      drain();

      stim_ms = TIME_W'(10000);
      rate_plan = '{7'd120, 7'd1, 7'd0, 7'd2, 7'd3, 7'd7, 7'd64};
      rate_plan.push_back(FW'($urandom_range(1, 120)));
      rate_plan.push_back(FW'($urandom_range(1, 120)));
      rate_plan.push_back(afrg_pkg::RESET_TARGET_FPS);
      foreach (rate_plan[i]) begin
         set_target(rate_plan[i]);
         add_session(PHASE_ITEMS);
         drain();
      end

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### adaptive_frame_rate_gate_top.f
rtl/afrg_pkg.sv
rtl/afrg_ctrl.sv
rtl/afrg_datapath.sv
rtl/adaptive_frame_rate_gate_top.sv
tb/sv/tb.sv
